FILE: rtl/wfps_pkg.sv
`default_nettype none
package wfps_pkg;

  // Frame geometry
  localparam int FRAME_SIZE = 1024;
  localparam int NYQ_BIN    = FRAME_SIZE / 2;
  localparam int POS_W      = $clog2(FRAME_SIZE);
  localparam int K_W        = $clog2(NYQ_BIN + 1);

  // Field widths
  localparam int MODE_W = 2;
  localparam int SMP_W  = 24;
  localparam int BIN_W  = 10;
  localparam int VAL_W  = 32;
  localparam int WIN_W  = 16;
  localparam int TW_W   = 18;
  localparam int IN_DW  = 72;
  localparam int OUT_DW = 40;

  // Datapath widths
  localparam int WPROD_W = SMP_W + WIN_W + 1;
  localparam int MPROD_W = SMP_W + TW_W;
  localparam int ACC_W   = MPROD_W + POS_W;
  localparam int AMP_SH  = POS_W + 8;
  localparam int AMP_W   = ACC_W - AMP_SH;
  localparam int SQ_W    = 2 * AMP_W;

  // Configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 10;
  localparam logic [CFG_AW-1:0] REG_START = 1'd0;
  localparam logic [CFG_AW-1:0] REG_AVG   = 1'd1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_READ,
    CMD_WRITE,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [SMP_W-1:0]   sample;
    logic [K_W-1:0]            bin;
    logic [VAL_W-1:0]          value;
  } cmd_t;

  // Trig constants
  localparam longint unsigned TWO_PI_Q40 = 64'd6908435304714;
  localparam longint signed   ONE_Q30    = 64'sd1073741824;
  localparam longint unsigned WIN_DEN    = FRAME_SIZE - 1;
  localparam longint unsigned WIN_DEN4   = 4 * (FRAME_SIZE - 1);
  localparam longint unsigned TW_DEN     = FRAME_SIZE;
  localparam longint unsigned TW_DEN4    = 4 * FRAME_SIZE;

  typedef longint unsigned div_tab_t [12];
  localparam div_tab_t COS_DIV = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};
  localparam div_tab_t SIN_DIV = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  typedef logic [WIN_W-1:0]       win_tab_t [FRAME_SIZE];
  typedef logic signed [TW_W-1:0] tw_tab_t  [FRAME_SIZE];

  // cos or sin of a turn fraction in Q30, Taylor series on a reduced quadrant
  function automatic longint signed turn(input longint unsigned p, input bit win,
                                         input bit want_sin);
    longint unsigned a, quad, rem, theta, th2, tc, ts;
    longint signed   cc, ss, c, s;
    if (win) begin
      a     = 4 * (p % WIN_DEN);
      quad  = a / WIN_DEN;
      rem   = a - quad * WIN_DEN;
      theta = ((rem * TWO_PI_Q40) / WIN_DEN4 + 512) >> 10;
    end else begin
      a     = 4 * (p % TW_DEN);
      quad  = a / TW_DEN;
      rem   = a - quad * TW_DEN;
      theta = ((rem * TWO_PI_Q40) / TW_DEN4 + 512) >> 10;
    end
    th2 = (theta * theta + (64'd1 << 29)) >> 30;
    tc  = 64'd1073741824;
    ts  = theta;
    cc  = 0;
    ss  = 0;
    for (int n = 0; n < 12; n++) begin
      if (n % 2 == 1) begin
        cc = cc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        cc = cc + longint'(tc);
        ss = ss + longint'(ts);
      end
      tc = ((tc * th2) >> 30) / COS_DIV[n];
      ts = ((ts * th2) >> 30) / SIN_DIV[n];
    end
    if (cc < 0) cc = 0;
    if (cc > ONE_Q30) cc = ONE_Q30;
    if (ss < 0) ss = 0;
    if (ss > ONE_Q30) ss = ONE_Q30;
    case (quad)
      0:       begin c = cc;  s = ss;  end
      1:       begin c = -ss; s = cc;  end
      2:       begin c = -cc; s = -ss; end
      default: begin c = ss;  s = -cc; end
    endcase
    return want_sin ? s : c;
  endfunction

  function automatic logic signed [TW_W-1:0] to_q16(input longint signed v);
    longint signed u;
    u = ((v + ONE_Q30 + 8192) >>> 14) - 65536;
    return TW_W'(u);
  endfunction

  function automatic win_tab_t build_win();
    win_tab_t       t;
    longint signed  w;
    for (int k = 0; k < FRAME_SIZE; k++) begin
      w = ((ONE_Q30 - turn(longint'(k), 1'b1, 1'b0)) + 16384) >>> 15;
      if (w > 65535) w = 65535;
      t[k] = WIN_W'(w);
    end
    return t;
  endfunction

  function automatic tw_tab_t build_tw(input bit want_sin);
    tw_tab_t t;
    for (int k = 0; k < FRAME_SIZE; k++) begin
      t[k] = to_q16(turn(longint'(k), 1'b0, want_sin));
    end
    return t;
  endfunction

  localparam win_tab_t WIN_TAB = build_win();
  localparam tw_tab_t  COS_TAB = build_tw(1'b0);
  localparam tw_tab_t  SIN_TAB = build_tw(1'b1);

endpackage
`default_nettype wire

FILE: rtl/wfps_front.sv
`default_nettype none
module wfps_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // mode[1:0], sample[25:2], bin_index[35:26], bin_value[67:36], zero pad
  input  wire logic [wfps_pkg::IN_DW-1:0] in_tdata,
  input  wire logic                       q_pop,
  output logic                            q_valid,
  output wfps_pkg::cmd_t                  q_cmd
);
  import wfps_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [BIN_W-1:0]  bin;
  logic              bin_ok;
  cmd_t              cmd;
  logic              push;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  // Classify the incoming item
  assign mode   = in_tdata[1:0];
  assign bin    = in_tdata[35:26];
  assign bin_ok = 32'(bin) <= 32'(NYQ_BIN);

  always_comb begin
    cmd.sample = in_tdata[25:2];
    cmd.bin    = K_W'(bin);
    cmd.value  = in_tdata[67:36];
    unique case (mode)
      MODE_PUSH:  cmd.kind = CMD_PUSH;
      MODE_READ:  cmd.kind = bin_ok ? CMD_READ : CMD_NONE;
      MODE_WRITE: cmd.kind = bin_ok ? CMD_WRITE : CMD_NONE;
      default:    cmd.kind = CMD_NONE;
    endcase
  end

  // Two-entry command queue
  assign in_tready = count_r != 2'd2;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = count_r != 2'd0;
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wfps_back.sv
`default_nettype none
module wfps_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [wfps_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [wfps_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                        q_valid,
  input  wire wfps_pkg::cmd_t              q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // frame_done[0], power_value[32:1], zero pad
  output logic [wfps_pkg::OUT_DW-1:0]      out_tdata
);
  import wfps_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WIN, S_STORE, S_DFT, S_DRAIN,
    S_POW1, S_POW2, S_POW3, S_READ
  } state_t;

  state_t state_r;

  // Memories
  logic [SMP_W-1:0] smp_mem [FRAME_SIZE];
  logic [VAL_W-1:0] pwr_mem [NYQ_BIN + 1];
  logic [VAL_W-1:0] cmp_mem [NYQ_BIN + 1];

  logic [POS_W-1:0] clr_r;
  logic [POS_W-1:0] pos_r;
  logic             avg_r;
  cmd_t             cmd_r;
  logic [WIN_W-1:0] win_r;
  logic signed [WPROD_W-1:0] wprod_r;

  logic [K_W-1:0]   k_r;
  logic [POS_W-1:0] n_r;
  logic [POS_W-1:0] m_r;
  logic             v1_r, v2_r;
  logic signed [SMP_W-1:0]   smp_rd_r;
  logic signed [TW_W-1:0]    cos_r, sin_r;
  logic signed [MPROD_W-1:0] pre_r, pim_r;
  logic signed [ACC_W-1:0]   acc_re_r, acc_im_r;
  logic [AMP_W-1:0] ar_r, ai_r;
  logic [SQ_W-1:0]  sqr_r, sqi_r;
  logic [VAL_W-1:0] pwr_rd_r, cmp_rd_r;

  logic             out_valid_r;
  logic             done_r;
  logic [VAL_W-1:0] power_r;

  // Combinational helpers
  logic                    out_free;
  logic                    out_set;
  logic                    issue;
  logic signed [WPROD_W-1:0] wround;
  logic [SMP_W-1:0]        wsample;
  logic [ACC_W-1:0]        mag_re, mag_im;
  logic [ACC_W-1:0]        rnd_re, rnd_im;
  logic [SQ_W:0]           tot;
  logic [SQ_W-30:0]        pw_raw;
  logic [VAL_W-1:0]        pw_sat;
  logic [VAL_W:0]          pw_sum;
  logic [VAL_W-1:0]        pw_fin;
  logic                    im_zero;

  logic             smp_we;
  logic [POS_W-1:0] smp_wa;
  logic [SMP_W-1:0] smp_wd;
  logic             pwr_we;
  logic [K_W-1:0]   pwr_wa;
  logic [VAL_W-1:0] pwr_wd;
  logic             cmp_we;
  logic [K_W-1:0]   cmp_wa;
  logic [VAL_W-1:0] cmp_wd;
  logic             clr_half;

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign issue    = state_r == S_DFT;
  assign clr_half = 32'(clr_r) <= 32'(NYQ_BIN);

  // An item finishes this cycle and loads the result register
  assign out_set = (q_pop && (q_cmd.kind inside {CMD_WRITE, CMD_NONE}))
                || (state_r == S_STORE && pos_r != POS_W'(FRAME_SIZE - 1))
                || (state_r == S_POW3 && 32'(k_r) == 32'(NYQ_BIN))
                || (state_r == S_READ);

  // Windowed sample, rounded half up
  assign wround  = wprod_r + WPROD_W'(32768);
  assign wsample = wround[SMP_W+15:16];

  // Bin amplitude and power
  assign mag_re  = acc_re_r[ACC_W-1] ? ACC_W'(-acc_re_r) : ACC_W'(acc_re_r);
  assign mag_im  = acc_im_r[ACC_W-1] ? ACC_W'(-acc_im_r) : ACC_W'(acc_im_r);
  assign rnd_re  = mag_re + (ACC_W'(1) << (AMP_SH - 1));
  assign rnd_im  = mag_im + (ACC_W'(1) << (AMP_SH - 1));
  assign im_zero = (k_r == '0) || (32'(k_r) == 32'(NYQ_BIN));
  assign tot     = (SQ_W + 1)'(sqr_r) + (SQ_W + 1)'(sqi_r) + ((SQ_W + 1)'(1) << 29);
  assign pw_raw  = tot[SQ_W:30];
  assign pw_sat  = (pw_raw > (SQ_W - 29)'(32'hFFFF_FFFF)) ? '1 : VAL_W'(pw_raw);
  assign pw_sum  = (VAL_W + 1)'(pw_sat) + (VAL_W + 1)'(cmp_rd_r);
  assign pw_fin  = avg_r ? pw_sum[VAL_W:1] : pw_sat;

  // Memory write selection
  always_comb begin
    smp_we = 1'b0;
    smp_wa = pos_r;
    smp_wd = wsample;
    pwr_we = 1'b0;
    pwr_wa = k_r;
    pwr_wd = pw_fin;
    cmp_we = 1'b0;
    cmp_wa = q_cmd.bin;
    cmp_wd = q_cmd.value;
    case (state_r)
      S_CLEAR: begin
        smp_we = 1'b1;
        smp_wa = clr_r;
        smp_wd = '0;
        pwr_we = clr_half;
        pwr_wa = K_W'(clr_r);
        pwr_wd = '0;
        cmp_we = clr_half;
        cmp_wa = K_W'(clr_r);
        cmp_wd = '0;
      end
      S_STORE: smp_we = 1'b1;
      S_POW3:  pwr_we = 1'b1;
      S_IDLE:  cmp_we = q_pop && (q_cmd.kind == CMD_WRITE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_wa] <= smp_wd;
    smp_rd_r <= smp_mem[n_r];
  end

  always_ff @(posedge clk) begin
    if (pwr_we) pwr_mem[pwr_wa] <= pwr_wd;
    pwr_rd_r <= pwr_mem[q_cmd.bin];
  end

  always_ff @(posedge clk) begin
    if (cmp_we) cmp_mem[cmp_wa] <= cmp_wd;
    cmp_rd_r <= cmp_mem[k_r];
  end

  // Table reads and the multiply-accumulate pipe
  always_ff @(posedge clk) begin
    win_r   <= WIN_TAB[pos_r];
    wprod_r <= $signed(cmd_r.sample) * $signed({1'b0, win_r});
    cos_r   <= COS_TAB[m_r];
    sin_r   <= SIN_TAB[m_r];
    pre_r   <= smp_rd_r * cos_r;
    pim_r   <= smp_rd_r * sin_r;
    ar_r    <= AMP_W'(rnd_re >> AMP_SH);
    ai_r    <= im_zero ? '0 : AMP_W'(rnd_im >> AMP_SH);
    sqr_r   <= ar_r * ar_r;
    sqi_r   <= ai_r * ai_r;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      avg_r       <= 1'b0;
      k_r         <= '0;
      n_r         <= '0;
      m_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r;
      if (v2_r) begin
        acc_re_r <= acc_re_r + ACC_W'(pre_r);
        acc_im_r <= acc_im_r - ACC_W'(pim_r);
      end
      if (cfg_we && cfg_addr == REG_START) pos_r <= POS_W'(cfg_wdata);
      if (cfg_we && cfg_addr == REG_AVG) avg_r <= cfg_wdata[0];

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == POS_W'(FRAME_SIZE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            case (q_cmd.kind)
              CMD_PUSH: state_r <= S_WIN;
              CMD_READ: state_r <= S_READ;
              default: begin
                done_r      <= 1'b0;
                power_r     <= '0;
              end
            endcase
          end
        end
        S_WIN: state_r <= S_STORE;
        S_STORE: begin
          if (pos_r == POS_W'(FRAME_SIZE - 1)) begin
            pos_r    <= '0;
            k_r      <= '0;
            n_r      <= '0;
            m_r      <= '0;
            acc_re_r <= '0;
            acc_im_r <= '0;
            state_r  <= S_DFT;
          end else begin
            pos_r       <= pos_r + 1'b1;
            done_r      <= 1'b0;
            power_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_DFT: begin
          n_r <= n_r + 1'b1;
          m_r <= m_r + POS_W'(k_r);
          if (n_r == POS_W'(FRAME_SIZE - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) state_r <= S_POW1;
        end
        S_POW1: state_r <= S_POW2;
        S_POW2: state_r <= S_POW3;
        S_POW3: begin
          if (32'(k_r) == 32'(NYQ_BIN)) begin
            done_r      <= 1'b1;
            power_r     <= '0;
            state_r     <= S_IDLE;
          end else begin
            k_r      <= k_r + 1'b1;
            n_r      <= '0;
            m_r      <= '0;
            acc_re_r <= '0;
            acc_im_r <= '0;
            state_r  <= S_DFT;
          end
        end
        S_READ: begin
          done_r      <= 1'b0;
          power_r     <= pwr_rd_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - VAL_W - 1)'(0), power_r, done_r};

  // A command is taken only while the result register can receive its item
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r || out_tready)) else $error("pop with result pending");

  // Bins never run past the Nyquist bin
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFT) |-> (32'(k_r) <= 32'(NYQ_BIN))) else $error("bin out of range");

  // A completed frame restarts at position zero
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POW3 && 32'(k_r) == 32'(NYQ_BIN)) |=> (pos_r == '0 && done_r))
    else $error("frame wrap");

  // The accumulator pipe is empty before a bin is turned into power
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POW1) |-> (!v1_r && !v2_r)) else $error("pipe not drained");

endmodule
`default_nettype wire

FILE: rtl/windowed_fft_power_spectrum.sv
`default_nettype none
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   mode, sample, bin_index, bin_value
// out_     out  out_tvalid/tready  frame_done, power_value
// cfg_     in   cfg_we             cfg_addr selects start_index or average_enable
//
// One result item per input item, in order. A push passes the window and store
// states, a bin read the read state; a companion write or an unused mode is answered
// as it is popped. The push that completes a frame runs a direct DFT on one
// multiply-accumulate unit over the sample memory port, (FRAME_SIZE/2+1) bins.
// After reset a clearing pass zeroes the stores; items wait in the two-entry
// queue meanwhile. Either side may stall freely.
module windowed_fft_power_spectrum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // mode[1:0], sample[25:2], bin_index[35:26], bin_value[67:36], zero pad
  input  wire logic [wfps_pkg::IN_DW-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // frame_done[0], power_value[32:1], zero pad
  output logic [wfps_pkg::OUT_DW-1:0]      out_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [wfps_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [wfps_pkg::CFG_DW-1:0] cfg_wdata
);
  import wfps_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  wfps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd)
  );

  wfps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
